/* design/dlks_pkg.sv */
package dlks_pkg;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    // Field widths
    localparam int LAYER_W  = 8;
    localparam int COORD_W  = 16;
    localparam int SPRITE_W = 20;
    localparam int TAG_W    = 16;
    localparam int FILL_W   = 7;
    localparam int KEY_W    = 1 + LAYER_W + 2 * COORD_W + SPRITE_W;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One stored draw entry
    typedef struct packed {
        logic                       dummy;
        logic [LAYER_W-1:0]         layer;
        logic signed [COORD_W-1:0]  pos_y;
        logic signed [COORD_W-1:0]  pos_x;
        logic [SPRITE_W-1:0]        sprite;
        logic [TAG_W-1:0]           tag;
    } t_entry;

    typedef logic [KEY_W-1:0] t_key;

    // Shift controls broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cmd;

    // Build the ordering key: dummies are all zero, others get a leading one,
    // and signed coordinates are biased so that an unsigned compare works.
    function automatic t_key make_key(input t_entry e);
        t_key k;
        if (e.dummy) begin
            k = '0;
        end else begin
            k = {1'b1, e.layer,
                 e.pos_y ^ {1'b1, {(COORD_W-1){1'b0}}},
                 e.pos_x ^ {1'b1, {(COORD_W-1){1'b0}}},
                 e.sprite};
        end
        return k;
    endfunction

endpackage

/* design/dlks_cell.sv */
module dlks_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dlks_pkg::t_cmd    i_cmd,
    input  dlks_pkg::t_entry  i_new_entry,
    input  dlks_pkg::t_key    i_new_key,
    input  dlks_pkg::t_entry  i_left_entry,
    input  logic              i_left_valid,
    input  logic              i_left_gt,
    input  dlks_pkg::t_entry  i_right_entry,
    input  logic              i_right_valid,
    output dlks_pkg::t_entry  o_entry,
    output logic              o_valid,
    output logic              o_gt
);

    dlks_pkg::t_entry r_entry, n_entry;
    logic             r_valid, n_valid;

    // Flag a cell whose entry sorts after the new one; empty cells count as after
    assign o_gt    = !r_valid || (dlks_pkg::make_key(r_entry) > i_new_key);
    assign o_entry = r_entry;
    assign o_valid = r_valid;

    // Choose the next contents: shift right on insert, shift left on pop
    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_cmd.ins) begin
            n_valid = r_valid | i_left_valid;
            if (i_left_gt) begin
                n_entry = i_left_entry;
            end else if (o_gt) begin
                n_entry = i_new_entry;
            end
        end else if (i_cmd.pop) begin
            n_entry = i_right_entry;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* design/draw_list_key_sorter_core.sv */
// Draw-list key sorter: a sorted store of up to DEPTH draw entries.
// Request channel: start with i_command and the entry fields; a request is
// taken at a rising edge where start is high and busy is low. busy stays low,
// so one request may be issued every cycle.
// Insert (command 0) places the entry at its key position: dummies first,
// then ascending layer, y, x, sprite; equal keys stay in arrival order.
// Pop (command 1) removes the smallest entry and returns its fields.
// Result channel: o_valid is high for exactly one cycle, in the cycle after the
// request, with o_status (ok, full-drop, empty-pop), the popped entry (zero on
// insert and on failure) and o_fill_level after the request.
// Throughput 1 request per cycle, set by the single
// compare-and-shift step each cell of the chain does per cycle.
// The receiver cannot stall; results must be taken when shown.
// Reset (synchronous, active low) empties the store by
// clearing the per-cell valid bits and the fill count; cell payload is kept.
module draw_list_key_sorter_core #(
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_command,
    input  logic                                 i_is_dummy,
    input  logic [dlks_pkg::LAYER_W-1:0]         i_layer,
    input  logic signed [dlks_pkg::COORD_W-1:0]  i_pos_y,
    input  logic signed [dlks_pkg::COORD_W-1:0]  i_pos_x,
    input  logic [dlks_pkg::SPRITE_W-1:0]        i_sprite,
    input  logic [dlks_pkg::TAG_W-1:0]           i_entry_tag,
    output logic                                 o_valid,
    output logic [1:0]                           o_status,
    output logic                                 o_out_dummy,
    output logic [dlks_pkg::LAYER_W-1:0]         o_out_layer,
    output logic signed [dlks_pkg::COORD_W-1:0]  o_out_y,
    output logic signed [dlks_pkg::COORD_W-1:0]  o_out_x,
    output logic [dlks_pkg::SPRITE_W-1:0]        o_out_sprite,
    output logic [dlks_pkg::TAG_W-1:0]           o_out_tag,
    output logic [dlks_pkg::FILL_W-1:0]          o_fill_level
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    dlks_pkg::t_cmd        w_cmd;
    dlks_pkg::t_entry      w_new_entry;
    dlks_pkg::t_key        w_new_key;
    dlks_pkg::t_entry      w_entry [DEPTH];
    logic [DEPTH-1:0]      w_valid;
    logic [DEPTH-1:0]      w_gt;

    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_strobe;
    dlks_pkg::t_status     r_status, n_status;
    dlks_pkg::t_entry      r_result, n_result;

    // Every request completes without a busy state
    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);

    assign w_new_entry = '{dummy: i_is_dummy, layer: i_layer, pos_y: i_pos_y,
                           pos_x: i_pos_x, sprite: i_sprite, tag: i_entry_tag};
    assign w_new_key   = dlks_pkg::make_key(w_new_entry);

    // Drop inserts into a full store and pops from an empty one
    assign w_cmd.ins = w_accept && (i_command == dlks_pkg::CMD_INSERT) && !w_full;
    assign w_cmd.pop = w_accept && (i_command == dlks_pkg::CMD_POP) && !w_empty;

    // Build the cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        dlks_pkg::t_entry w_left_entry, w_right_entry;
        logic             w_left_valid, w_left_gt, w_right_valid;

        if (g == 0) begin : g_head
            assign w_left_entry = w_new_entry;
            assign w_left_valid = 1'b1;
            assign w_left_gt    = 1'b0;
        end else begin : g_mid_l
            assign w_left_entry = w_entry[g-1];
            assign w_left_valid = w_valid[g-1];
            assign w_left_gt    = w_gt[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_entry = w_entry[g];
            assign w_right_valid = 1'b0;
        end else begin : g_mid_r
            assign w_right_entry = w_entry[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        dlks_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_new_entry   (w_new_entry),
            .i_new_key     (w_new_key),
            .i_left_entry  (w_left_entry),
            .i_left_valid  (w_left_valid),
            .i_left_gt     (w_left_gt),
            .i_right_entry (w_right_entry),
            .i_right_valid (w_right_valid),
            .o_entry       (w_entry[g]),
            .o_valid       (w_valid[g]),
            .o_gt          (w_gt[g])
        );
    end

    // Work out status, returned entry and new fill count
    always_comb begin
        n_count  = r_count;
        n_status = dlks_pkg::ST_OK;
        n_result = '0;
        if (w_accept) begin
            unique case (i_command)
                dlks_pkg::CMD_INSERT: begin
                    if (w_full) begin
                        n_status = dlks_pkg::ST_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                dlks_pkg::CMD_POP: begin
                    if (w_empty) begin
                        n_status = dlks_pkg::ST_EMPTY;
                    end else begin
                        n_count  = r_count - CNT_W'(1);
                        n_result = w_entry[0];
                    end
                end
                default: begin
                    n_status = dlks_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_result <= n_result;
    end

    assign o_valid      = r_strobe;
    assign o_status     = r_status;
    assign o_out_dummy  = r_result.dummy;
    assign o_out_layer  = r_result.layer;
    assign o_out_y      = r_result.pos_y;
    assign o_out_x      = r_result.pos_x;
    assign o_out_sprite = r_result.sprite;
    assign o_out_tag    = r_result.tag;
    assign o_fill_level = dlks_pkg::FILL_W'(r_count);

`ifndef SYNTHESIS
    a_strobe_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("result strobe missing after request");

    a_no_spurious_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_valid)
        else $error("result strobe without request");

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("fill count disagrees with cell valid bits");

    a_valid_is_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + DEPTH'(1))) == '0)
        else $error("valid cells are not a contiguous prefix");

    a_empty_pop_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == dlks_pkg::ST_EMPTY)) |-> (r_count == '0))
        else $error("empty status with entries held");
`endif

endmodule
